// ===== design/rgma_pkg.sv =====
// ----------------------------------------------------------------------------
// rgma_pkg: shared types, constants and FP32 arithmetic
// Lane types, register decode constants and the bit-exact fused multiply-add
// used both by the mix datapath and by the gain ramp adders.
// ----------------------------------------------------------------------------
`default_nettype none

package rgma_pkg;

   localparam int LANES  = 4;
   localparam int PHASES = 4;

   typedef logic [31:0]             fp32_type;
   typedef fp32_type [LANES-1:0]    lane_vec_type;
   typedef logic [47:0]             prod_type;
   typedef prod_type [LANES-1:0]    prod_vec_type;

   localparam logic [3:0] CSR_STEP_BASE = 4'd4;
   localparam logic [3:0] CSR_COUNT     = 4'd8;

   // Cycles the derived gain registers need after a register write.
   localparam logic [1:0] SETTLE_CYCLES = 2'd3;

   localparam fp32_type DEFAULT_NAN = 32'h7FC0_0000;
   localparam fp32_type ONE_BITS    = 32'h3F80_0000;
   localparam fp32_type QUIET_BIT   = 32'h0040_0000;
   localparam fp32_type NEG_ZERO    = 32'h8000_0000;

   function automatic logic is_nan(input fp32_type x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input fp32_type x);
      return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
   endfunction

   function automatic logic is_zero(input fp32_type x);
      return x[30:0] == 31'd0;
   endfunction

   function automatic fp32_type flush(input fp32_type x);
      return (x[30:23] == 8'd0) ? {x[31], 31'd0} : x;
   endfunction

   function automatic logic [23:0] mant_of(input fp32_type x);
      return {(x[30:23] != 8'd0), x[22:0]};
   endfunction

   function automatic int exp_of(input fp32_type x);
      return (x[30:23] != 8'd0) ? (int'(x[30:23]) - 150) : -149;
   endfunction

   function automatic int top_bit(input logic [63:0] v);
      int n;
      n = 0;
      for (int i = 1; i < 64; i++) begin
         if (v[i]) n = i;
      end
      return n;
   endfunction

   // Rounds sign * mag * 2^ex to FP32, nearest even; mag must be nonzero.
   function automatic fp32_type round_pack(input logic sign, input logic [63:0] mag,
                                           input int ex);
      int          t;
      int          q;
      int          rs;
      int          be;
      logic [63:0] sig;
      logic [63:0] rem;
      logic [63:0] half;
      fp32_type    res;
      t = top_bit(mag) + ex;
      q = (t >= -126) ? t - 23 : -149;
      rs = q - ex;
      if (rs <= 0) begin
         sig = mag << (0 - rs);
      end else if (rs >= 64) begin
         sig = '0;
      end else begin
         rem  = mag & ((64'd1 << rs) - 64'd1);
         half = 64'd1 << (rs - 1);
         sig  = mag >> rs;
         if (rem > half || (rem == half && sig[0])) sig = sig + 64'd1;
      end
      if (sig == (64'd1 << 24)) begin
         sig = sig >> 1;
         q = q + 1;
      end
      if (sig >= (64'd1 << 23)) begin
         be = q + 150;
         if (be >= 255) res = {sign, 8'hFF, 23'd0};
         else res = {sign, be[7:0], sig[22:0]};
      end else begin
         res = {sign, 8'd0, sig[22:0]};
      end
      return res;
   endfunction

   // Second half of a fused a*b+c: mp is the product of the significands.
   function automatic fp32_type fma_finish(input fp32_type a, input fp32_type b,
                                           input fp32_type c, input prod_type mp);
      logic        sp;
      logic        sl;
      logic        ss;
      logic        lost;
      logic [63:0] mp64;
      logic [63:0] mc;
      logic [63:0] ml;
      logic [63:0] ms;
      logic [63:0] la;
      logic [63:0] sal;
      int          ep;
      int          ec;
      int          el;
      int          es;
      int          sh;
      int          eal;
      int          k;
      fp32_type    res;
      sp   = a[31] ^ b[31];
      mp64 = {16'd0, mp};
      mc   = {40'd0, mant_of(c)};
      ep   = exp_of(a) + exp_of(b);
      ec   = exp_of(c);
      res  = '0;
      if (is_nan(a)) begin
         res = a | QUIET_BIT;
      end else if (is_nan(b)) begin
         res = b | QUIET_BIT;
      end else if (is_nan(c)) begin
         res = c | QUIET_BIT;
      end else if (is_inf(a) || is_inf(b)) begin
         if (is_zero(a) || is_zero(b)) res = DEFAULT_NAN;
         else if (is_inf(c) && (c[31] != sp)) res = DEFAULT_NAN;
         else res = {sp, 8'hFF, 23'd0};
      end else if (is_inf(c)) begin
         res = c;
      end else if (mp64 == 64'd0) begin
         if (mc == 64'd0) res = (sp && c[31]) ? NEG_ZERO : '0;
         else res = c;
      end else if (mc == 64'd0) begin
         res = round_pack(sp, mp64, ep);
      end else begin
         if (top_bit(mp64) + ep >= top_bit(mc) + ec) begin
            ml = mp64; el = ep; sl = sp;
            ms = mc;   es = ec; ss = c[31];
         end else begin
            ml = mc;   el = ec; sl = c[31];
            ms = mp64; es = ep; ss = sp;
         end
         sh  = 61 - top_bit(ml);
         la  = ml << sh;
         eal = el - sh;
         k   = es - eal;
         if (k >= 0) begin
            sal = ms << k;
         end else if (k <= -64) begin
            sal = 64'd1;
         end else begin
            lost = (ms & ((64'd1 << (0 - k)) - 64'd1)) != 64'd0;
            sal  = (ms >> (0 - k)) | {63'd0, lost};
         end
         if (sl == ss) res = round_pack(sl, la + sal, eal);
         else if (la == sal) res = '0;
         else if (la > sal) res = round_pack(sl, la - sal, eal);
         else res = round_pack(ss, sal - la, eal);
      end
      return res;
   endfunction

   // Plain FP32 add, subnormals kept; times one is a shift of the significand.
   function automatic fp32_type fp_add(input fp32_type x, input fp32_type y);
      prod_type mp;
      mp = {1'b0, mant_of(x), 23'd0};
      return fma_finish(x, ONE_BITS, y, mp);
   endfunction

endpackage

`default_nettype wire

// ===== design/rgma_req_if.sv =====
// ----------------------------------------------------------------------------
// rgma_req_if: input vector channel
// Valid/ready channel carrying four samples and four mix values.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgma_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_lane0;
   logic [31:0] sample_lane1;
   logic [31:0] sample_lane2;
   logic [31:0] sample_lane3;
   logic [31:0] mix_lane0;
   logic [31:0] mix_lane1;
   logic [31:0] mix_lane2;
   logic [31:0] mix_lane3;

   modport source (output valid, sample_lane0, sample_lane1, sample_lane2, sample_lane3,
                   mix_lane0, mix_lane1, mix_lane2, mix_lane3, input ready);
   modport sink   (input valid, sample_lane0, sample_lane1, sample_lane2, sample_lane3,
                   mix_lane0, mix_lane1, mix_lane2, mix_lane3, output ready);
endinterface

`default_nettype wire

// ===== design/rgma_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rgma_rsp_if: result vector channel
// Valid/ready channel carrying four new mix values and the block end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgma_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_lane0;
   logic [31:0] result_lane1;
   logic [31:0] result_lane2;
   logic [31:0] result_lane3;
   logic        block_end;

   modport source (output valid, result_lane0, result_lane1, result_lane2, result_lane3,
                   block_end, input ready);
   modport sink   (input valid, result_lane0, result_lane1, result_lane2, result_lane3,
                   block_end, output ready);
endinterface

`default_nettype wire

// ===== design/rgma_csr_if.sv =====
// ----------------------------------------------------------------------------
// rgma_csr_if: register write channel
// Valid/ready channel carrying a register index and 32-bit write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgma_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/ramped_gain_mix_accumulate.sv =====
// ----------------------------------------------------------------------------
// ramped_gain_mix_accumulate: four-lane FP32 mix with ramped gain
// Computes mix + sample * gain per lane as a fused multiply-add, with the
// gain of each lane ramping linearly across a block of vectors.
// ----------------------------------------------------------------------------
//   channel  direction  carries
//   req_if   in         sample_lane0..3, mix_lane0..3
//   rsp_if   out        result_lane0..3, block_end
//   csr_if   in         index, data (register writes, always ready)
//
// One beat per cycle is accepted while the pipeline is not stalled; a result
// passes through three register stages (flush/gain select, significand multiply,
// align/add/round) before it is valid on rsp_if.
// The whole pipeline stalls while a result beat waits on rsp_if.
// After reset or a register write, req_if is held off while the derived gain
// registers recompute.
// ----------------------------------------------------------------------------
`default_nettype none

module ramped_gain_mix_accumulate #(
   parameter int VECTORS_PER_BLOCK = 64
) (
   input  wire          clock,
   input  wire          reset,
   rgma_req_if.sink     req_if,
   rgma_rsp_if.source   rsp_if,
   rgma_csr_if.sink     csr_if
);

   localparam int POS_W = $clog2(VECTORS_PER_BLOCK);
   localparam int L     = rgma_pkg::LANES;

   rgma_pkg::lane_vec_type cfg_start_ff;
   rgma_pkg::lane_vec_type cfg_step_ff;
   rgma_pkg::lane_vec_type two_ff, d1_ff, three_ff, d2_ff, four_ff, d3_ff;
   rgma_pkg::lane_vec_type phase_gain_ff [rgma_pkg::PHASES];
   rgma_pkg::lane_vec_type group_step_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [1:0]             settle_ff;

   logic                   s0_valid_ff, s0_end_ff;
   rgma_pkg::lane_vec_type s0_a_ff, s0_b_ff, s0_c_ff;
   logic                   s1_valid_ff, s1_end_ff;
   rgma_pkg::lane_vec_type s1_a_ff, s1_b_ff, s1_c_ff;
   rgma_pkg::prod_vec_type s1_mp_ff;
   logic                   out_valid_ff, out_end_ff;
   rgma_pkg::lane_vec_type out_res_ff;

   rgma_pkg::lane_vec_type sample_in, mix_in, gain_sel, gain_upd;
   logic                   advance, accept, first, last;
   logic [1:0]             phase;

   assign advance = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = advance && (settle_ff == 2'd0);
   assign accept = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign first = pos_ff == '0;
   assign last  = pos_ff == POS_W'(VECTORS_PER_BLOCK - 1);
   assign phase = pos_ff[1:0];

   assign sample_in = {req_if.sample_lane3, req_if.sample_lane2,
                       req_if.sample_lane1, req_if.sample_lane0};
   assign mix_in    = {req_if.mix_lane3, req_if.mix_lane2,
                       req_if.mix_lane1, req_if.mix_lane0};

   // At a block start the gains come straight from the registers.
   always_comb begin
      for (int l = 0; l < L; l++) begin
         gain_sel[l] = first ? cfg_start_ff[l] : phase_gain_ff[phase][l];
         gain_upd[l] = rgma_pkg::fp_add(gain_sel[l], first ? four_ff[l] : group_step_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_start_ff <= '0;
         cfg_step_ff  <= '0;
         settle_ff    <= rgma_pkg::SETTLE_CYCLES;
      end else if (csr_if.valid) begin
         if (csr_if.index < rgma_pkg::CSR_STEP_BASE) begin
            cfg_start_ff[csr_if.index[1:0]] <= csr_if.data;
         end else if (csr_if.index < rgma_pkg::CSR_COUNT) begin
            cfg_step_ff[csr_if.index[1:0]] <= csr_if.data;
         end
         settle_ff <= rgma_pkg::SETTLE_CYCLES;
      end else if (settle_ff != 2'd0) begin
         settle_ff <= settle_ff - 2'd1;
      end
   end

   // Block-start gains, formed from the registers in three add levels.
   always_ff @(posedge clock) begin
      for (int l = 0; l < L; l++) begin
         two_ff[l]   <= rgma_pkg::fp_add(cfg_step_ff[l], cfg_step_ff[l]);
         d1_ff[l]    <= rgma_pkg::fp_add(cfg_start_ff[l], cfg_step_ff[l]);
         three_ff[l] <= rgma_pkg::fp_add(two_ff[l], cfg_step_ff[l]);
         d2_ff[l]    <= rgma_pkg::fp_add(cfg_start_ff[l], two_ff[l]);
         four_ff[l]  <= rgma_pkg::fp_add(two_ff[l], two_ff[l]);
         d3_ff[l]    <= rgma_pkg::fp_add(cfg_start_ff[l], three_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (accept) begin
         pos_ff <= last ? '0 : pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (first) begin
            phase_gain_ff[0] <= gain_upd;
            phase_gain_ff[1] <= d1_ff;
            phase_gain_ff[2] <= d2_ff;
            phase_gain_ff[3] <= d3_ff;
            group_step_ff    <= four_ff;
         end else begin
            phase_gain_ff[phase] <= gain_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff  <= accept;
         s1_valid_ff  <= s0_valid_ff;
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_end_ff  <= last;
         s1_end_ff  <= s0_end_ff;
         out_end_ff <= s1_end_ff;
         s1_a_ff    <= s0_a_ff;
         s1_b_ff    <= s0_b_ff;
         s1_c_ff    <= s0_c_ff;
         for (int l = 0; l < L; l++) begin
            s0_a_ff[l]    <= rgma_pkg::flush(sample_in[l]);
            s0_b_ff[l]    <= rgma_pkg::flush(gain_sel[l]);
            s0_c_ff[l]    <= rgma_pkg::flush(mix_in[l]);
            s1_mp_ff[l]   <= rgma_pkg::mant_of(s0_a_ff[l]) * rgma_pkg::mant_of(s0_b_ff[l]);
            out_res_ff[l] <= rgma_pkg::fma_finish(s1_a_ff[l], s1_b_ff[l], s1_c_ff[l],
                                                  s1_mp_ff[l]);
         end
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.result_lane0 = out_res_ff[0];
   assign rsp_if.result_lane1 = out_res_ff[1];
   assign rsp_if.result_lane2 = out_res_ff[2];
   assign rsp_if.result_lane3 = out_res_ff[3];
   assign rsp_if.block_end    = out_end_ff;

   a_csr_holds_off_req: assert property (@(posedge clock) disable iff (reset)
      csr_if.valid |=> !(req_if.valid && req_if.ready))
      else $error("vector beat taken while derived gains settle");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(VECTORS_PER_BLOCK - 1))
      else $error("vector position beyond block length");

   a_pos_wraps: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (pos_ff == '0))
      else $error("vector position did not wrap at block end");

   a_pipe_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance) |=> out_valid_ff)
      else $error("result lost between multiply and output stage");

endmodule

`default_nettype wire
